[rtl/core/tst_pkg.sv]
// Package for the timer slot table: sizes, command codes, beat and slot types.
`timescale 1ns / 1ps
`default_nettype none
package tst_pkg;

	// Table size and fire limit per process command
	localparam int SLOTS       = 8;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NF_W        = $clog2(MAX_RESULTS + 1);

	// Command codes
	localparam logic [2:0] CMD_START_SHORT = 3'd0;
	localparam logic [2:0] CMD_START_LONG  = 3'd1;
	localparam logic [2:0] CMD_CANCEL      = 3'd2;
	localparam logic [2:0] CMD_QUERY       = 3'd3;
	localparam logic [2:0] CMD_PROCESS     = 3'd4;

	// Result kinds
	localparam logic KIND_FIRED = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] count;
		logic [7:0]  callback_id;
		logic [15:0] data_tag;
		logic        tick_pending;
		logic        second_pending;
	} cmd_beat_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  fired_callback;
		logic [15:0] fired_tag;
		logic        running;
		logic        last_of_run;
	} res_beat_t;

	typedef struct packed {
		logic [7:0]  callback;
		logic [15:0] tag;
		logic [15:0] ticks;
		logic [15:0] seconds;
		logic        armed;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage
`default_nettype wire

[rtl/core/tst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/timer_slot_table.sv]
// Timer slot table: command sequencer over a slot RAM with fired/query result queue.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  cmd     | in  | cmd_valid/cmd_ready | command, count, id, tag, pending
//  res     | out | res_valid/res_ready | kind, fired id/tag, running, last
//
// Every command walks all slots through the single RAM read port, one slot
// per cycle while no fire stalls the walk.
// A fire stalls the walk while a result is held and the output beat is full and not taken.
// Reset clears the per-slot valid bits; an unwritten slot reads as all zero.
// A new command is taken once the previous one has queued its last result.
`timescale 1ns / 1ps
`default_nettype none
module timer_slot_table
	import tst_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	input  wire cmd_beat_t cmd,
	output logic           res_valid,
	input  wire logic      res_ready,
	output res_beat_t      res
);

	state_t              state_q, state_d;
	cmd_beat_t           cmd_q;
	logic [IDX_W-1:0]    idx_q;
	logic                done_q, run_q;
	logic [NF_W-1:0]     nfire_q;
	logic                hold_v_q;
	res_beat_t           hold_q;
	logic                res_valid_q;
	res_beat_t           res_q;
	logic [SLOTS-1:0]    slot_vld_q;
	logic                vld_rd_q;

	logic                ram_we, ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	slot_t               ram_wdata, ram_rdata, slot_cur;

	logic                cmd_acc, res_free, last_idx, stall, scan_go;
	logic                id_match, tag_match, hit, do_wr, fire, done_set;
	logic [15:0]         ticks_dec, secs_dec;
	logic                res_load;
	res_beat_t           res_d;
	logic                flush_done;

	// slot storage
	tst_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign slot_cur = vld_rd_q ? ram_rdata : '0;
	assign cmd_acc  = cmd_valid && cmd_ready;
	assign res_free = !res_valid_q || res_ready;
	assign last_idx = (idx_q == IDX_W'(SLOTS - 1));

	// per-slot evaluation of the current command
	always_comb begin
		id_match  = (slot_cur.callback == cmd_q.callback_id);
		tag_match = (slot_cur.tag == cmd_q.data_tag);
		ticks_dec = (cmd_q.tick_pending && slot_cur.ticks != '0) ?
			slot_cur.ticks - 16'd1 : slot_cur.ticks;
		secs_dec  = (cmd_q.second_pending && slot_cur.seconds != '0) ?
			slot_cur.seconds - 16'd1 : slot_cur.seconds;
		ram_wdata = slot_cur;
		hit       = 1'b0;
		do_wr     = 1'b0;
		fire      = 1'b0;
		done_set  = 1'b0;
		case (cmd_q.command)
			CMD_START_SHORT, CMD_START_LONG: begin
				if (cmd_q.callback_id != '0 && !done_q &&
					((id_match && tag_match) || slot_cur.callback == '0)) begin
					hit                = 1'b1;
					do_wr              = 1'b1;
					done_set           = 1'b1;
					ram_wdata.callback = cmd_q.callback_id;
					ram_wdata.tag      = cmd_q.data_tag;
					ram_wdata.ticks    = (cmd_q.command == CMD_START_LONG) ? '0 : cmd_q.count;
					ram_wdata.seconds  = (cmd_q.command == CMD_START_LONG) ? cmd_q.count : '0;
					ram_wdata.armed    = 1'b1;
				end
			end
			CMD_CANCEL: begin
				if (!done_q && id_match && (cmd_q.data_tag == '0 || tag_match)) begin
					hit                = 1'b1;
					do_wr              = 1'b1;
					done_set           = (cmd_q.data_tag != '0);
					ram_wdata.callback = '0;
					ram_wdata.tag      = '0;
				end
			end
			CMD_QUERY: begin
				hit = id_match && (cmd_q.data_tag == '0 || tag_match);
			end
			CMD_PROCESS: begin
				do_wr = 1'b1;
				fire  = slot_cur.callback != '0 && slot_cur.armed && ticks_dec == '0 &&
					secs_dec == '0 && nfire_q < NF_W'(MAX_RESULTS);
				if (fire) begin
					ram_wdata = '0;
				end else begin
					ram_wdata.ticks   = ticks_dec;
					ram_wdata.seconds = secs_dec;
				end
			end
			default: begin
			end
		endcase
	end

	// a fire needs room to push the held result out
	assign stall   = fire && hold_v_q && !res_free;
	assign scan_go = (state_q == ST_SCAN) && !stall;

	// flush: query answer or the held final fire
	always_comb begin
		flush_done = 1'b1;
		if (cmd_q.command == CMD_QUERY || (cmd_q.command == CMD_PROCESS && hold_v_q)) begin
			flush_done = res_free;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_go && last_idx) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (flush_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs: RAM control and result loading
	always_comb begin
		cmd_ready = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		res_load  = 1'b0;
		res_d     = hold_q;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				ram_re    = cmd_valid;
			end
			ST_SCAN: begin
				ram_we    = scan_go && do_wr;
				ram_re    = scan_go && !last_idx;
				ram_raddr = idx_q + IDX_W'(1);
				if (scan_go && fire && hold_v_q) begin
					res_load          = 1'b1;
					res_d.last_of_run = 1'b0;
				end
			end
			ST_FLUSH: begin
				if (res_free) begin
					if (cmd_q.command == CMD_QUERY) begin
						res_load             = 1'b1;
						res_d                = '0;
						res_d.result_kind    = KIND_QUERY;
						res_d.running        = run_q;
						res_d.last_of_run    = 1'b1;
					end else if (cmd_q.command == CMD_PROCESS && hold_v_q) begin
						res_load          = 1'b1;
						res_d.last_of_run = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cmd_q    <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
			run_q    <= 1'b0;
			nfire_q  <= '0;
			hold_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_acc) begin
				cmd_q   <= cmd;
				idx_q   <= '0;
				done_q  <= 1'b0;
				run_q   <= 1'b0;
				nfire_q <= '0;
			end
			if (scan_go) begin
				idx_q  <= idx_q + IDX_W'(1);
				done_q <= done_q | done_set;
				if (cmd_q.command == CMD_QUERY) run_q <= run_q | hit;
				if (fire) begin
					nfire_q  <= nfire_q + NF_W'(1);
					hold_v_q <= 1'b1;
				end
			end
			if (state_q == ST_FLUSH && res_load && cmd_q.command == CMD_PROCESS) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	// held fire, payload only
	always_ff @(posedge clk) begin
		if (scan_go && fire) begin
			hold_q <= '{
				result_kind:    KIND_FIRED,
				fired_callback: slot_cur.callback,
				fired_tag:      slot_cur.tag,
				running:        1'b0,
				last_of_run:    1'b0
			};
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// slot valid bits: a never-written slot reads as free and zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
			vld_rd_q   <= 1'b0;
		end else begin
			if (ram_we) slot_vld_q[idx_q] <= 1'b1;
			if (ram_re) vld_rd_q <= slot_vld_q[ram_raddr];
		end
	end

`ifndef ASSERT_OFF
	// no fire may be left behind when a new command is taken
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> !hold_v_q)
		else $error("held fire pending while idle");

	// fire count stays within the per-command limit
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		nfire_q <= NF_W'(MAX_RESULTS))
		else $error("fire count over limit");

	// the walk never reads the slot it writes back in the same cycle
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_raddr != idx_q))
		else $error("read and write hit the same slot");

	// a stalled walk keeps its slot index
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && stall) |=> $stable(idx_q))
		else $error("slot index moved during stall");
`endif

endmodule
`default_nettype wire
